>>> rtl/core/hri_pkg.sv
// hri_pkg: shared constants for the halton radical inverse block
// no dependencies; used by every file under rtl/core
`timescale 1ns / 1ps

package hri_pkg;

	// default widths of the index and of the fraction
	localparam int INDEX_BITS_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 32;

	// base register
	localparam int         BASE_W     = 8;
	localparam logic [7:0] RADIX_RST  = 8'd2;
	localparam logic [7:0] RADIX_MIN  = 8'd2;

	// restoring division steps done per cycle in digit extraction
	localparam int DIV_STEPS = 4;

endpackage

>>> rtl/core/hri_front.sv
// hri_front: input stage; takes words from the input side and tags zero indexes
// depends on hri_pkg (defaults only); feeds hri_queue
`timescale 1ns / 1ps

module hri_front #(
	parameter int INDEX_BITS = hri_pkg::INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [INDEX_BITS-1:0] sample_index,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [INDEX_BITS:0]   q_wdata
);

	logic                  valid_s1;
	logic                  zero_s1;
	logic [INDEX_BITS-1:0] index_s1;

	assign q_push  = valid_s1 && !q_full;
	assign full    = valid_s1 && q_full;
	assign q_wdata = {zero_s1, index_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (push && !full) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			index_s1 <= sample_index;
			zero_s1  <= (sample_index == '0);
		end
	end

endmodule

>>> rtl/core/hri_queue.sv
// hri_queue: two-entry word queue between the front and back parts
// depends on hri_pkg (defaults only)
`timescale 1ns / 1ps

module hri_queue #(
	parameter int WIDTH = hri_pkg::INDEX_BITS_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             q_empty,
	output logic             q_full
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign q_empty = (count_q == 2'd0);
	assign q_full  = (count_q == 2'd2);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/core/hri_back.sv
// hri_back: digit extraction, mirrored integer build and final fraction division
// depends on hri_pkg; reads words from hri_queue and holds the result register
`timescale 1ns / 1ps

module hri_back #(
	parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
	parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [hri_pkg::BASE_W-1:0] base,
	input  logic                      q_empty,
	input  logic [INDEX_BITS:0]       q_rdata,
	output logic                      q_pop,
	output logic                      res_valid,
	output logic [FRACTION_BITS-1:0]  res_data,
	input  logic                      res_pop
);

	localparam int BW         = hri_pkg::BASE_W;
	localparam int STEPS      = hri_pkg::DIV_STEPS;
	localparam int DIV_CYCLES = (INDEX_BITS + STEPS - 1) / STEPS;
	localparam int DIV_W      = DIV_CYCLES * STEPS;
	localparam int POW_W      = INDEX_BITS + BW;
	localparam int CNT_MAX    = (FRACTION_BITS > DIV_CYCLES) ? FRACTION_BITS : DIV_CYCLES;
	localparam int CNT_W      = $clog2(CNT_MAX + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_FRAC = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [DIV_W-1:0]         quo_q;
	logic [BW-1:0]            rem_q;
	logic [POW_W-1:0]         m_q;
	logic [POW_W-1:0]         pow_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic                     res_valid_q;
	logic [FRACTION_BITS-1:0] res_q;

	logic [BW-1:0]      div_rem;
	logic [STEPS-1:0]   div_qbits;
	logic [POW_W-1:0]   m_next;
	logic [POW_W-1:0]   pow_next;
	logic [POW_W:0]     fr_shift;
	logic [POW_W:0]     fr_diff;
	logic               fr_ge;
	logic               res_load;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign res_load  = (state_q == ST_DONE) && (!res_valid_q || res_pop);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// DIV_STEPS restoring steps per cycle; remainder stays below the base
	always_comb begin
		logic [BW:0] r;
		r         = {1'b0, rem_q};
		div_qbits = '0;
		for (int i = 0; i < STEPS; i++) begin
			r = {r[BW-1:0], quo_q[DIV_W-1-i]};
			if (r >= {1'b0, base}) begin
				r = r - {1'b0, base};
				div_qbits[STEPS-1-i] = 1'b1;
			end
		end
		div_rem = r[BW-1:0];
	end

	// digits arrive least significant first, so m = m * b + d mirrors them
	assign m_next   = (m_q * {{(POW_W-BW){1'b0}}, base}) + {{(POW_W-BW){1'b0}}, rem_q};
	assign pow_next = pow_q * {{(POW_W-BW){1'b0}}, base};

	// m_q doubles as the remainder of m * 2^F / b^k
	assign fr_shift = {m_q, 1'b0};
	assign fr_ge    = (fr_shift >= {1'b0, pow_q});
	assign fr_diff  = fr_shift - {1'b0, pow_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (!q_empty) begin
						state_q <= q_rdata[INDEX_BITS] ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_CYCLES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_ACC: begin
					cnt_q   <= '0;
					state_q <= (quo_q == '0) ? ST_FRAC : ST_DIV;
				end
				ST_FRAC: begin
					if (cnt_q == CNT_W'(FRACTION_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= frac_q;
		end
		case (state_q)
			ST_IDLE: begin
				quo_q  <= DIV_W'(q_rdata[INDEX_BITS-1:0]);
				rem_q  <= '0;
				m_q    <= '0;
				pow_q  <= POW_W'(1);
				frac_q <= '0;
			end
			ST_DIV: begin
				quo_q <= {quo_q[DIV_W-STEPS-1:0], div_qbits};
				rem_q <= div_rem;
			end
			ST_ACC: begin
				m_q   <= m_next;
				pow_q <= pow_next;
				rem_q <= '0;
			end
			ST_FRAC: begin
				m_q    <= fr_ge ? fr_diff[POW_W-1:0] : fr_shift[POW_W-1:0];
				frac_q <= {frac_q[FRACTION_BITS-2:0], fr_ge};
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/halton_radical_inverse.sv
// halton radical inverse: an accepted index passes through the input stage and the queue to
// the back part, which extracts its base digits (index zero skips straight to the result);
// the back part holds one word at a time, the input stage and queue taking further words meanwhile.
// the digit loop runs four restoring division steps a cycle, then one multiply-accumulate
// step per digit; the final division yields one fraction bit a cycle. reset (arst_n low,
`timescale 1ns / 1ps
// asynchronous) empties the input stage, the queue and the result register and sets the stored base to 2

module halton_radical_inverse #(
	parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
	parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [INDEX_BITS-1:0]      sample_index,
	output logic                       empty,
	input  logic                       pop,
	output logic [FRACTION_BITS-1:0]   fraction_value,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hri_pkg::BASE_W-1:0] radix_base
);

	logic [hri_pkg::BASE_W-1:0] radix_q;
	logic                       q_push;
	logic [INDEX_BITS:0]        q_wdata;
	logic                       q_pop;
	logic [INDEX_BITS:0]        q_rdata;
	logic                       q_empty;
	logic                       q_full;
	logic                       res_valid;

	assign cfg_ready = 1'b1;
	assign empty     = !res_valid;

	// bases below two behave as base two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= hri_pkg::RADIX_RST;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= (radix_base < hri_pkg::RADIX_MIN) ? hri_pkg::RADIX_MIN : radix_base;
		end
	end

	hri_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_index(sample_index),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	hri_queue #(
		.WIDTH(INDEX_BITS + 1)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wdata),
		.rd_en  (q_pop),
		.rd_data(q_rdata),
		.q_empty(q_empty),
		.q_full (q_full)
	);

	hri_back #(
		.INDEX_BITS   (INDEX_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.base     (radix_q),
		.q_empty  (q_empty),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res_data (fraction_value),
		.res_pop  (pop)
	);

endmodule

>>> rtl/core/hri_checker.sv
// hri_checker: port-level assertions for halton_radical_inverse
// depends on hri_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module hri_checker #(
	parameter int INDEX_BITS    = hri_pkg::INDEX_BITS_DEF,
	parameter int FRACTION_BITS = hri_pkg::FRACTION_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     push,
	input logic                     full,
	input logic                     empty,
	input logic                     pop,
	input logic [FRACTION_BITS-1:0] fraction_value
);

	// a waiting result stays until popped
	a_res_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped without pop");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(fraction_value))
		else $error("waiting result changed");

	// the input stage only fills up when a word was taken
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full)
		else $error("full rose without a push");

	a_res_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown(fraction_value))
		else $error("result word has unknown bits");

endmodule

bind halton_radical_inverse hri_checker #(
	.INDEX_BITS   (INDEX_BITS),
	.FRACTION_BITS(FRACTION_BITS)
) u_hri_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.push          (push),
	.full          (full),
	.empty         (empty),
	.pop           (pop),
	.fraction_value(fraction_value)
);

>>> dv/tb_halton_radical_inverse.sv
// tb_halton_radical_inverse: self-checking testbench for the halton radical inverse block
// depends on rtl/core/hri_pkg.sv and rtl/core/halton_radical_inverse.sv
// predicts each fraction by exact horner division and checks it in order of arrival
`timescale 1ns / 1ps

module tb_halton_radical_inverse;

	localparam int IDX_W  = hri_pkg::INDEX_BITS_DEF;
	localparam int FRAC_W = hri_pkg::FRACTION_BITS_DEF;

	class fraction_scoreboard;
		logic [hri_pkg::BASE_W-1:0] base = hri_pkg::RADIX_RST;
		logic [FRAC_W-1:0] pending_fractions[$];
		int unsigned       mismatches = 0;
		int unsigned       checked = 0;
		int unsigned       indices_seen = 0;

		// exact floor(2^F * mirrored / base^digits), most significant index digit first
		function logic [FRAC_W-1:0] radical_inverse(logic [IDX_W-1:0] idx);
			logic [7:0]  digit[0:63];
			logic [63:0] rest;
			logic [63:0] acc;
			logic [63:0] b;
			int          n;
			int          i;
			b = (base < hri_pkg::RADIX_MIN) ? 64'(hri_pkg::RADIX_MIN) : 64'(base);
			rest = 64'(idx);
			acc = '0;
			n = 0;
			while (rest != 0) begin
				digit[n] = 8'(rest % b);
				rest = rest / b;
				n++;
			end
			for (i = n - 1; i >= 0; i--) begin
				acc = ((64'(digit[i]) << FRAC_W) + acc) / b;
			end
			return acc[FRAC_W-1:0];
		endfunction

		function void note_index(logic [IDX_W-1:0] idx);
			pending_fractions.push_back(radical_inverse(idx));
			indices_seen++;
		endfunction

		function void check_fraction(logic [FRAC_W-1:0] got);
			logic [FRAC_W-1:0] want;
			if (pending_fractions.size() == 0) begin
				$error("fraction_value: no word expected, got %08h", got);
				mismatches++;
				return;
			end
			want = pending_fractions.pop_front();
			checked++;
			if (got !== want) begin
				$error("fraction_value: expected %08h, actual %08h", want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic [IDX_W-1:0]           sample_index;
	logic                       empty;
	logic                       pop;
	logic [FRAC_W-1:0]          fraction_value;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [hri_pkg::BASE_W-1:0] radix_base;

	fraction_scoreboard sb = new();

	logic [IDX_W-1:0] index_queue[$];
	int unsigned      send_idle = 0;
	int unsigned      recv_stall = 0;
	int unsigned      hold_request = 0;
	int unsigned      full_stalls = 0;
	int unsigned      base_writes = 0;

	halton_radical_inverse #(
		.INDEX_BITS(IDX_W),
		.FRACTION_BITS(FRAC_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample_index(sample_index),
		.empty(empty),
		.pop(pop),
		.fraction_value(fraction_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.radix_base(radix_base)
	);

	always #5 clk = ~clk;

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stalls, plus a long hold-off when one is requested
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_fraction(fraction_value);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= arst_n && ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// offer every queued index until the block has taken all of them
	task automatic push_items();
		while (index_queue.size() != 0) begin
			if ($urandom_range(99) >= send_idle) begin
				push <= 1'b1;
				sample_index <= index_queue[0];
			end else begin
				push <= 1'b0;
			end
			@(posedge clk);
			if (push && full)
				full_stalls++;
			if (push && !full) begin
				sb.note_index(sample_index);
				void'(index_queue.pop_front());
			end
		end
		push <= 1'b0;
	endtask

	task automatic wait_drain();
		while (sb.pending_fractions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_base(input logic [hri_pkg::BASE_W-1:0] b);
		cfg_valid <= 1'b1;
		radix_base <= b;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.base = b;
		base_writes++;
	endtask

	// full range, small, near a power of the base, or a shifted random word
	function automatic logic [IDX_W-1:0] pick_index(logic [hri_pkg::BASE_W-1:0] b);
		logic [63:0] p;
		int unsigned j;
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 4095);
			2: begin
				p = 1;
				j = $urandom_range(0, 31);
				while (j != 0 && p * b <= 64'hFFFF_FFFF) begin
					p = p * b;
					j--;
				end
				p = p + $urandom_range(0, 2) - 1;
				return p[IDX_W-1:0];
			end
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	initial begin
		logic [hri_pkg::BASE_W-1:0] phase_base[8];
		int                         p;
		int                         i;
		phase_base = '{8'd3, 8'd2, 8'd255, 8'd5, 8'd7, 8'd13, 8'd254, 8'd128};
		arst_n <= 1'b0;
		push <= 1'b0;
		sample_index <= '0;
		cfg_valid <= 1'b0;
		radix_base <= hri_pkg::RADIX_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// base after reset, index extremes and alternating bits
		index_queue = '{32'h0, 32'h1, 32'h2, 32'h3, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF};
		push_items();
		wait_drain();

		// widest base: one digit, two digits, top of range
		write_base(8'd255);
		index_queue = '{32'h0, 32'd1, 32'd254, 32'd255, 32'd256, 32'd65024, 32'd65025,
			32'hFFFF_FFFF, 32'hFFFF_FFFE};
		push_items();
		wait_drain();

		// receiver holds off while the sender keeps offering, so the block backs up
		hold_request = 4000;
		for (i = 0; i < 60; i++)
			index_queue.push_back($urandom_range(1, 254));
		push_items();
		wait_drain();

		for (p = 0; p < 8; p++) begin
			phase_base[7] = (p == 7) ? 8'($urandom_range(hri_pkg::RADIX_MIN, 255))
				: phase_base[7];
			write_base(phase_base[p]);
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 79; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 79; end
				default: begin send_idle = 23; recv_stall = 23; end
			endcase
			for (i = 0; i < 85; i++)
				index_queue.push_back(pick_index(phase_base[p]));
			push_items();
			wait_drain();
		end

		send_idle = 0;
		recv_stall = 0;
		repeat (340) @(posedge clk);

		$display("%0d indices over %0d base settings, %0d fractions checked",
			sb.indices_seen, base_writes + 1, sb.checked);
		$display("input held off by full for %0d cycles over the whole run",
			full_stalls);
		if (sb.mismatches == 0 && sb.pending_fractions.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
